FILE: rtl/akf_pkg.sv
// ----------------------------------------------------------------------------
// Angle and rate Kalman filter package
// Shared types, state codes and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package akf_pkg;

   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_NOISE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_NOISE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAS_NOISE  = 3'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M_PRED,
      ST_M_SUMC,
      ST_M_BBDT,
      ST_D_INIT,
      ST_DIV0,
      ST_DIV1,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'(MAX32)) begin
         r = MAX32;
      end else if (v < 34'(MIN32)) begin
         r = MIN32;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat34(34'(a) + 34'(b));
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat34(34'(a) - 34'(b));
   endfunction

endpackage

FILE: rtl/akf_if.sv
// ----------------------------------------------------------------------------
// Angle and rate Kalman filter channel interfaces
// Valid/ready channels for sample transactions and estimate transactions.
// ----------------------------------------------------------------------------
interface akf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_sample;
   logic signed [31:0] rate_sample;
   modport source (output valid, output angle_sample, output rate_sample, input ready);
   modport sink   (input valid, input angle_sample, input rate_sample, output ready);
endinterface

interface akf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_estimate;
   logic signed [31:0] rate_estimate;
   modport source (output valid, output angle_estimate, output rate_estimate, input ready);
   modport sink   (input valid, input angle_estimate, input rate_estimate, output ready);
endinterface

FILE: rtl/akf_div.sv
// ----------------------------------------------------------------------------
// Angle and rate Kalman filter gain divider
// Bit-serial restoring divider computing sat32((num << FRAC_BITS) / den).
// ----------------------------------------------------------------------------
module akf_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [31:0]        num,
   input  logic signed [33:0]        den,
   output akf_pkg::div_ctl_type      ctl,
   output logic signed [31:0]        quot
);
   import akf_pkg::*;

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW);
   localparam logic [NW-1:0] LIM = NW'(64'h8000_0000);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] dq_ff, dq_in;
   logic [33:0]   rem_ff, rem_in;
   logic [33:0]   dmag_ff, dmag_in;
   logic          neg_ff, neg_in;
   logic          zero_ff, zero_in;
   logic [34:0]   trial;
   logic [31:0]   nmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      nmag    = num[31] ? 32'(-num) : 32'(num);
      trial   = {rem_ff, dq_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = {nmag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dmag_in = den[33] ? 34'(-den) : 34'(den);
         neg_in  = num[31] ^ den[33];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = 34'(trial - {1'b0, dmag_ff});
            dq_in  = {dq_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[33:0];
            dq_in  = {dq_ff[NW-2:0], 1'b0};
         end
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (zero_ff) begin
         quot = '0;
      end else if (neg_ff) begin
         quot = (dq_ff > LIM) ? MIN32 : -$signed(dq_ff[31:0]);
      end else begin
         quot = (dq_ff >= LIM) ? MAX32 : $signed(dq_ff[31:0]);
      end
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;

endmodule

FILE: rtl/angle_gyro_kalman_filter.sv
// ----------------------------------------------------------------------------
// Angle and gyro bias Kalman filter
// Two-state filter fusing angle and rate samples, with one shared multiplier
// and a bit-serial gain divider under a sequencer.
// ----------------------------------------------------------------------------
// One transaction is in work at a time: a new one is taken only once the last
// has left its final step. The serial divider, run twice per transaction at one
// quotient bit per cycle, takes most of the time of each transaction. A result
// still waiting at the output holds the block in its last step.
// Reset restores the register defaults, zero angle and bias, and an identity
// covariance; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module angle_gyro_kalman_filter #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   akf_req_if.sink                               req_ch,
   akf_rsp_if.source                             rsp_ch,
   input  logic                                  csr_we,
   input  logic [akf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [akf_pkg::CSR_DATA_W-1:0]        csr_data
);
   import akf_pkg::*;

   localparam int SW = (FRAC_BITS > 16) ? FRAC_BITS + 1 : 17;
   localparam int MW = (FRAC_BITS > 16) ? FRAC_BITS + 7 : 23;
   localparam int ONE = 1 << FRAC_BITS;
   localparam logic [SW-1:0] TS_RST = SW'((ONE + 50) / 100);
   localparam logic [SW-1:0] QA_RST = SW'((2 * ONE + 500) / 1000);
   localparam logic [SW-1:0] QB_RST = SW'((35 * ONE + 5000) / 10000);
   localparam logic [MW-1:0] R_RST  = MW'((6 * ONE + 5) / 10);
   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   state_type state_ff, state_in;

   logic [SW-1:0] dt_ff, qa_ff, qb_ff;
   logic [MW-1:0] r_ff;

   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [31:0] am_ff, am_in, wm_ff, wm_in, diff_ff, diff_in;
   logic signed [31:0] pred_ff, pred_in, err_ff, err_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, rate_ff, rate_in;
   logic signed [31:0] rsp_angle_ff, rsp_angle_in, rsp_rate_ff, rsp_rate_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, rsum, rsh;
   logic signed [31:0] rnd;

   logic               div_start;
   logic signed [31:0] div_num, div_q;
   logic signed [33:0] div_den;
   div_ctl_type        div_ctl;

   akf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .ctl   (div_ctl),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= TS_RST;
         qa_ff <= QA_RST;
         qb_ff <= QB_RST;
         r_ff  <= R_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP:   dt_ff <= SW'(csr_data[16:0]);
            CSR_ANGLE_NOISE: qa_ff <= SW'(csr_data[16:0]);
            CSR_BIAS_NOISE:  qb_ff <= SW'(csr_data[16:0]);
            CSR_MEAS_NOISE:  r_ff  <= MW'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         bias_ff      <= '0;
         aa_ff        <= 32'(ONE);
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= 32'(ONE);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         aa_ff        <= aa_in;
         ab_ff        <= ab_in;
         ba_ff        <= ba_in;
         bb_ff        <= bb_in;
      end
      am_ff   <= am_in;
      wm_ff   <= wm_in;
      diff_ff <= diff_in;
      pred_ff <= pred_in;
      err_ff  <= err_in;
      p00_ff  <= p00_in;
      p01_ff  <= p01_in;
      p10_ff  <= p10_in;
      p11_ff  <= p11_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
      rate_ff <= rate_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_rate_ff  <= rsp_rate_in;
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      rsum = prod_ff + HALF;
      rsh  = rsum >>> FRAC_BITS;
      if (rsh > 66'(MAX32)) begin
         rnd = MAX32;
      end else if (rsh < 66'(MIN32)) begin
         rnd = MIN32;
      end else begin
         rnd = rsh[31:0];
      end
   end

   assign div_den = 34'(p00_ff) + 34'($signed({1'b0, r_ff}));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      angle_in = angle_ff;
      bias_in  = bias_ff;
      aa_in    = aa_ff;
      ab_in    = ab_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      am_in    = am_ff;
      wm_in    = wm_ff;
      diff_in  = diff_ff;
      pred_in  = pred_ff;
      err_in   = err_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      rate_in  = rate_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_rate_in  = rsp_rate_ff;
      mul_a    = '0;
      mul_b    = '0;
      div_start = 1'b0;
      div_num   = p00_ff;
      req_ch.ready = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               am_in    = req_ch.angle_sample;
               wm_in    = req_ch.rate_sample;
               diff_in  = sub_sat(req_ch.rate_sample, bias_ff);
               state_in = ST_M_PRED;
            end
         end
         ST_M_PRED: begin
            mul_a    = 33'(diff_ff);
            mul_b    = 33'($signed({1'b0, dt_ff}));
            state_in = ST_M_SUMC;
         end
         ST_M_SUMC: begin
            mul_a    = 33'(add_sat(ab_ff, ba_ff));
            mul_b    = 33'($signed({1'b0, dt_ff}));
            pred_in  = add_sat(angle_ff, rnd);
            state_in = ST_M_BBDT;
         end
         ST_M_BBDT: begin
            mul_a    = 33'(bb_ff);
            mul_b    = 33'($signed({1'b0, dt_ff}));
            err_in   = sub_sat(am_ff, pred_ff);
            p00_in   = sub_sat(add_sat(aa_ff, 32'($signed({1'b0, qa_ff}))), rnd);
            state_in = ST_D_INIT;
         end
         ST_D_INIT: begin
            p01_in    = sub_sat(ab_ff, rnd);
            p10_in    = sub_sat(ba_ff, rnd);
            p11_in    = add_sat(bb_ff, 32'($signed({1'b0, qb_ff})));
            div_start = 1'b1;
            div_num   = p00_ff;
            state_in  = ST_DIV0;
         end
         ST_DIV0: begin
            if (div_ctl.done) begin
               k0_in     = div_q;
               div_start = 1'b1;
               div_num   = p10_ff;
               state_in  = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_ctl.done) begin
               k1_in    = div_q;
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            mul_a    = 33'(k0_ff);
            mul_b    = 33'(err_ff);
            state_in = ST_M2;
         end
         ST_M2: begin
            mul_a    = 33'(k1_ff);
            mul_b    = 33'(err_ff);
            angle_in = add_sat(pred_ff, rnd);
            state_in = ST_M3;
         end
         ST_M3: begin
            mul_a    = 33'(k0_ff);
            mul_b    = 33'(p00_ff);
            bias_in  = add_sat(bias_ff, rnd);
            state_in = ST_M4;
         end
         ST_M4: begin
            mul_a    = 33'(k0_ff);
            mul_b    = 33'(p01_ff);
            aa_in    = sub_sat(p00_ff, rnd);
            rate_in  = sub_sat(wm_ff, bias_ff);
            state_in = ST_M5;
         end
         ST_M5: begin
            mul_a    = 33'(k1_ff);
            mul_b    = 33'(p00_ff);
            ab_in    = sub_sat(p01_ff, rnd);
            state_in = ST_M6;
         end
         ST_M6: begin
            mul_a    = 33'(k1_ff);
            mul_b    = 33'(p01_ff);
            ba_in    = sub_sat(p10_ff, rnd);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            mul_a = 33'(k1_ff);
            mul_b = 33'(p01_ff);
            bb_in = sub_sat(p11_ff, rnd);
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = angle_ff;
               rsp_rate_in  = rate_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.angle_estimate = rsp_angle_ff;
   assign rsp_ch.rate_estimate  = rsp_rate_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (state_ff == ST_IDLE))
      else $error("Input accepted while a transaction is in work.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> rsp_valid_ff)
      else $error("Finished transaction did not raise the result valid.");

   assert property (@(posedge clock) disable iff (reset)
      div_ctl.done |-> (state_ff == ST_DIV0 || state_ff == ST_DIV1))
      else $error("Divider finished outside a gain step.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(rsp_angle_ff)))
      else $error("Pending result changed before it was taken.");

endmodule
